>>> rtl/cpf_check_digit_validator_core_assert.svh
// Assertion macros for the CPF check digit validator.
// Each macro takes a label, an antecedent and a consequent, and is clocked on
// clk and held off while rst is high.
`ifndef CPF_CHECK_DIGIT_VALIDATOR_CORE_ASSERT_SVH
`define CPF_CHECK_DIGIT_VALIDATOR_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define CPF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpf assertion failed (same cycle)");

// Consequent holds in the cycle after the antecedent.
`define CPF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpf assertion failed (next cycle)");

`endif

>>> rtl/cpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpf_pkg
// Shared types, constants and small arithmetic helpers for the CPF validator.
// ----------------------------------------------------------------------------
package cpf_pkg;

  localparam logic [3:0] CPF_LEN     = 4'd11;
  localparam logic [3:0] COUNT_SAT   = 4'd12;
  localparam logic [3:0] POS_TENTH   = 4'd9;
  localparam logic [3:0] POS_ELEVEN  = 4'd10;
  localparam logic [3:0] W_FIRST_TOP = 4'd10;
  localparam logic [3:0] W_SECND_TOP = 4'd11;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [6:0] MOD_BASE    = 7'd11;
  // floor(v * 46 / 512) is v/11 or one below it for any v < 128
  localparam logic [12:0] MOD_RECIP  = 13'd46;

  typedef struct packed {
    logic       is_digit;
    logic [3:0] digit;
    logic       last;
  } cpf_item_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
    logic       empty;
  } cpf_q_stat_t;

  // v mod 11 for a 7-bit value, reciprocal estimate plus one correction
  function automatic logic [3:0] mod11(input logic [6:0] v);
    logic [12:0] prod;
    logic [3:0]  q;
    logic [6:0]  m;
    logic [6:0]  r;
    prod = 13'(v) * MOD_RECIP;
    q    = prod[12:9];
    m    = 7'(q) * MOD_BASE;
    r    = v - m;
    if (r >= MOD_BASE) begin
      r = r - MOD_BASE;
    end
    return r[3:0];
  endfunction

  // check digit from a mod-11 remainder
  function automatic logic [3:0] check_of(input logic [3:0] rem);
    logic [3:0] chk;
    if (rem < 4'd2) begin
      chk = 4'd0;
    end else begin
      chk = W_SECND_TOP - rem;
    end
    return chk;
  endfunction

endpackage

>>> rtl/cpf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpf_front
// Input side: accept characters and classify them as digit or other.
// ----------------------------------------------------------------------------
module cpf_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           ch,
  input  logic                 last,
  input  logic                 q_full,
  output logic                 push,
  output cpf_pkg::cpf_item_t   push_item
);

  logic [7:0] ofs;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign ofs      = ch - cpf_pkg::CHAR_ZERO;

  always_comb begin
    push_item.is_digit = (ch >= cpf_pkg::CHAR_ZERO) && (ch <= cpf_pkg::CHAR_NINE);
    push_item.digit    = ofs[3:0];
    push_item.last     = last;
  end

endmodule

>>> rtl/cpf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpf_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module cpf_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cpf_pkg::cpf_item_t   push_item,
  input  logic                 pop,
  output cpf_pkg::cpf_item_t   pop_item,
  output cpf_pkg::cpf_q_stat_t stat
);

  cpf_pkg::cpf_item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  assign pop_item   = mem[rd_ptr];
  assign stat.count = count;
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

  always_comb begin
    count_next = count + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> rtl/cpf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpf_back
// Execution side: fold digits into mod-11 sums and issue the verdict.
// ----------------------------------------------------------------------------
module cpf_back (
  input  logic                 clk,
  input  logic                 rst,
  input  cpf_pkg::cpf_item_t   item,
  input  logic                 item_avail,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 valid_res
);

  logic [3:0] digit_count, digit_count_next;
  logic [3:0] rem_first, rem_first_next;
  logic [3:0] rem_second, rem_second_next;
  logic [3:0] first_digit, first_digit_next;
  logic       all_same, all_same_next;
  logic [3:0] tenth_digit, tenth_digit_next;
  logic [3:0] eleventh_digit, eleventh_digit_next;
  logic [3:0] w_first, w_second;
  logic [7:0] p_first, p_second;
  logic       verdict;

  assign pop = item_avail && (!out_valid || out_ready);

  assign w_first  = cpf_pkg::W_FIRST_TOP - digit_count;
  assign w_second = cpf_pkg::W_SECND_TOP - digit_count;
  assign p_first  = 8'(item.digit) * 8'(w_first);
  assign p_second = 8'(item.digit) * 8'(w_second);

  always_comb begin
    digit_count_next    = digit_count;
    rem_first_next      = rem_first;
    rem_second_next     = rem_second;
    first_digit_next    = first_digit;
    all_same_next       = all_same;
    tenth_digit_next    = tenth_digit;
    eleventh_digit_next = eleventh_digit;
    if (item.is_digit && (digit_count < cpf_pkg::COUNT_SAT)) begin
      if (digit_count == 4'd0) begin
        first_digit_next = item.digit;
      end else if (item.digit != first_digit) begin
        all_same_next = 1'b0;
      end
      if (digit_count < cpf_pkg::POS_TENTH) begin
        rem_first_next = cpf_pkg::mod11(7'(rem_first) + p_first[6:0]);
      end
      if (digit_count < cpf_pkg::POS_ELEVEN) begin
        rem_second_next = cpf_pkg::mod11(7'(rem_second) + p_second[6:0]);
      end
      if (digit_count == cpf_pkg::POS_TENTH) begin
        tenth_digit_next = item.digit;
      end
      if (digit_count == cpf_pkg::POS_ELEVEN) begin
        eleventh_digit_next = item.digit;
      end
      digit_count_next = digit_count + 4'd1;
    end
    verdict = (digit_count_next == cpf_pkg::CPF_LEN) && !all_same_next
              && (cpf_pkg::check_of(rem_first_next) == tenth_digit_next)
              && (cpf_pkg::check_of(rem_second_next) == eleventh_digit_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      digit_count    <= 4'd0;
      rem_first      <= 4'd0;
      rem_second     <= 4'd0;
      first_digit    <= 4'd0;
      all_same       <= 1'b1;
      tenth_digit    <= 4'd0;
      eleventh_digit <= 4'd0;
    end else begin
      if (pop && item.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (item.last) begin
          digit_count    <= 4'd0;
          rem_first      <= 4'd0;
          rem_second     <= 4'd0;
          first_digit    <= 4'd0;
          all_same       <= 1'b1;
          tenth_digit    <= 4'd0;
          eleventh_digit <= 4'd0;
        end else begin
          digit_count    <= digit_count_next;
          rem_first      <= rem_first_next;
          rem_second     <= rem_second_next;
          first_digit    <= first_digit_next;
          all_same       <= all_same_next;
          tenth_digit    <= tenth_digit_next;
          eleventh_digit <= eleventh_digit_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && item.last) begin
      valid_res <= verdict;
    end
  end

endmodule

>>> rtl/cpf_check_digit_validator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpf_check_digit_validator_core
// CPF mod-11 check digit validator: one character in, one verdict per string.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  input   | in_valid / in_ready  | ch[7:0], last (ends a string)
//  output  | out_valid / out_ready| valid_res (1 = identifier passes)
//
// One character per cycle sustained while the output is not stalled. A
// character is classified on entry and queued; the back end pops it from the
// queue and folds it into the mod-11 sums, and the verdict for a string is
// registered when its last character is popped, so out_valid rises only
// after that character has passed through a queue entry.
// Reset clears the queue, the digit state and out_valid (not valid_res); no
// clearing pass. A stalled output holds the back end; the two-entry queue
// keeps accepting until full, then drops in_ready.
// ----------------------------------------------------------------------------
module cpf_check_digit_validator_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       valid_res
);

`include "cpf_check_digit_validator_core_assert.svh"

  logic                 push;
  logic                 pop;
  cpf_pkg::cpf_item_t   push_item;
  cpf_pkg::cpf_item_t   pop_item;
  cpf_pkg::cpf_q_stat_t q_stat;

  // Classify each character as it is taken in.
  cpf_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .last      (last),
    .q_full    (q_stat.full),
    .push      (push),
    .push_item (push_item)
  );

  // Decouple input acceptance from the arithmetic side.
  cpf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  // Advance the running sums and register the verdict.
  cpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (pop_item),
    .item_avail (!q_stat.empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .valid_res  (valid_res)
  );

  // Never pop an empty queue.
  `CPF_ASSERT_NOW(a_pop_nonempty, pop, !q_stat.empty)
  // Occupancy never exceeds the two entries.
  `CPF_ASSERT_NOW(a_q_bound, 1'b1, q_stat.count != 2'd3)
  // A verdict appears only after a string-ending item left the queue.
  `CPF_ASSERT_NOW(a_res_from_last, $rose(out_valid), $past(pop && pop_item.last))
  // A stalled verdict blocks the back end.
  `CPF_ASSERT_NOW(a_back_holds, out_valid && !out_ready, !pop)

endmodule
